>>> rtl/dsd_pkg.sv
// Shared constants and the power-of-five table for the decimal to binary64 converter.
// No dependencies.
`default_nettype none
package dsd_pkg;
  localparam int unsigned MaxExponent = 20;
  localparam int unsigned Pow5Bits = 47;
  localparam int unsigned WideBits = 128;
  localparam logic [12:0] ExpBias = 13'd1023;

  // Powers of five up to the largest supported exponent.
  function automatic logic [Pow5Bits-1:0] pow5(input logic [4:0] idx);
    logic [Pow5Bits-1:0] v;
    case (idx)
      5'd0: v = 47'd1;
      5'd1: v = 47'd5;
      5'd2: v = 47'd25;
      5'd3: v = 47'd125;
      5'd4: v = 47'd625;
      5'd5: v = 47'd3125;
      5'd6: v = 47'd15625;
      5'd7: v = 47'd78125;
      5'd8: v = 47'd390625;
      5'd9: v = 47'd1953125;
      5'd10: v = 47'd9765625;
      5'd11: v = 47'd48828125;
      5'd12: v = 47'd244140625;
      5'd13: v = 47'd1220703125;
      5'd14: v = 47'd6103515625;
      5'd15: v = 47'd30517578125;
      5'd16: v = 47'd152587890625;
      5'd17: v = 47'd762939453125;
      5'd18: v = 47'd3814697265625;
      5'd19: v = 47'd19073486328125;
      5'd20: v = 47'd95367431640625;
      default: v = 47'd1;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

>>> rtl/decimal_scientific_to_double_unit.sv
// Top level of the decimal scientific to binary64 converter: sequencer and datapath.
// Depends on dsd_pkg.
//
// Channel   Direction  Handshake           Payload
// input     in         start high, busy low  in_mantissa, in_exponent_negative,
//                                           in_decimal_exponent
// result    out        out_valid strobe    out_result_bits, out_range_error
//
// A positive exponent runs the shift-add multiply (MUL), then normalize (NORM) and round
// (ROUND). A negative exponent runs mantissa normalize (MNORM), a restoring divide (DIV),
// normalize (NORM) and round (ROUND). Zero mantissa and range errors answer in the cycle
// after the item. Reset is synchronous; the receiver cannot stall.
`default_nettype none
module decimal_scientific_to_double_unit
  import dsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] in_mantissa,
  input  wire logic        in_exponent_negative,
  input  wire logic [5:0]  in_decimal_exponent,
  output logic             out_valid,
  output logic [63:0]      out_result_bits,
  output logic             out_range_error
);
  typedef enum logic [2:0] {IDLE, MUL, MNORM, DIV, NORM, ROUND} state_t;

  state_t state_r, state_nxt;
  logic [WideBits-1:0] val_r, val_nxt, mcand_r, mcand_nxt;
  logic [Pow5Bits-1:0] mplr_r, mplr_nxt, div_r, div_nxt;
  logic [Pow5Bits:0] rem_r, rem_nxt;
  logic [63:0] m_r, m_nxt;
  logic [5:0] lz_r, lz_nxt;
  logic [6:0] cnt_r, cnt_nxt, lpos_r, lpos_nxt;
  logic [4:0] e_r, e_nxt;
  logic neg_r, neg_nxt;
  logic valid_r, valid_nxt, err_r, err_nxt;
  logic [63:0] res_r, res_nxt;

  logic [Pow5Bits:0] trial;
  logic [6:0] shamt;
  logic [63:0] top;
  logic rup;
  logic [53:0] sig;
  logic [12:0] bexp, expo;

  // Round arithmetic on the normalized top 64 bits.
  always_comb begin
    trial = {rem_r[Pow5Bits-1:0], val_r[WideBits-1]};
    shamt = 7'(3 * e_r) + 7'd1;
    top = val_r[WideBits-1:WideBits-64];
    rup = top[10] && (top[9:0] != 10'd0 || top[11]);
    sig = {1'b0, top[63:11]} + 54'(rup);
    if (neg_r) begin
      bexp = 13'd0 - (13'({e_r, 2'b00}) + 13'(lz_r) + 13'd1);
    end else begin
      bexp = 13'(e_r);
    end
    expo = 13'(lpos_r) + ExpBias + bexp + 13'(sig[53]);
  end

  // Sequencer next-state and datapath.
  always_comb begin
    state_nxt = state_r;
    val_nxt = val_r;
    mcand_nxt = mcand_r;
    mplr_nxt = mplr_r;
    div_nxt = div_r;
    rem_nxt = rem_r;
    m_nxt = m_r;
    lz_nxt = lz_r;
    cnt_nxt = cnt_r;
    lpos_nxt = lpos_r;
    e_nxt = e_r;
    neg_nxt = neg_r;
    valid_nxt = 1'b0;
    err_nxt = err_r;
    res_nxt = res_r;
    case (state_r)
      IDLE: begin
        if (start) begin
          e_nxt = in_decimal_exponent[4:0];
          neg_nxt = in_exponent_negative;
          if (32'(in_decimal_exponent) > MaxExponent) begin
            valid_nxt = 1'b1;
            err_nxt = 1'b1;
            res_nxt = 64'd0;
          end else if (in_mantissa == 64'd0) begin
            valid_nxt = 1'b1;
            err_nxt = 1'b0;
            res_nxt = 64'd0;
          end else if (!in_exponent_negative) begin
            val_nxt = '0;
            mcand_nxt = {64'd0, in_mantissa};
            mplr_nxt = pow5(in_decimal_exponent[4:0]);
            cnt_nxt = '0;
            state_nxt = MUL;
          end else begin
            m_nxt = in_mantissa;
            lz_nxt = '0;
            div_nxt = pow5(in_decimal_exponent[4:0]);
            state_nxt = MNORM;
          end
        end
      end
      MUL: begin
        if (mplr_r[0]) val_nxt = val_r + mcand_r;
        mcand_nxt = mcand_r << 1;
        mplr_nxt = mplr_r >> 1;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(Pow5Bits - 1)) begin
          lpos_nxt = 7'(WideBits - 1);
          state_nxt = NORM;
        end
      end
      MNORM: begin
        if (m_r[63]) begin
          val_nxt = {64'd0, m_r} << shamt;
          rem_nxt = '0;
          cnt_nxt = '0;
          state_nxt = DIV;
        end else begin
          m_nxt = m_r << 1;
          lz_nxt = lz_r + 6'd1;
        end
      end
      DIV: begin
        // Restoring divide: quotient bits shift in where dividend bits leave.
        if (trial >= {1'b0, div_r}) begin
          rem_nxt = trial - {1'b0, div_r};
          val_nxt = {val_r[WideBits-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          val_nxt = {val_r[WideBits-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(WideBits - 1)) begin
          lpos_nxt = 7'(WideBits - 1);
          state_nxt = NORM;
        end
      end
      NORM: begin
        if (val_r[WideBits-1]) begin
          state_nxt = ROUND;
        end else begin
          val_nxt = val_r << 1;
          lpos_nxt = lpos_r - 7'd1;
        end
      end
      ROUND: begin
        res_nxt = {1'b0, expo[10:0], sig[53] ? sig[52:1] : sig[51:0]};
        err_nxt = 1'b0;
        valid_nxt = 1'b1;
        state_nxt = IDLE;
      end
      default: state_nxt = IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      valid_r <= 1'b0;
      err_r <= 1'b0;
      res_r <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      err_r <= err_nxt;
      res_r <= res_nxt;
    end
    val_r <= val_nxt;
    mcand_r <= mcand_nxt;
    mplr_r <= mplr_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    m_r <= m_nxt;
    lz_r <= lz_nxt;
    cnt_r <= cnt_nxt;
    lpos_r <= lpos_nxt;
    e_r <= e_nxt;
    neg_r <= neg_nxt;
  end

  assign busy = (state_r != IDLE);
  assign out_valid = valid_r;
  assign out_result_bits = res_r;
  assign out_range_error = err_r;
endmodule
`default_nettype wire

>>> rtl/dsd_checker.sv
// Port-level checks for the converter, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module dsd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [63:0] out_result_bits,
  input wire logic        out_range_error
);
  // A result follows an accepted item or the end of a busy stretch.
  a_valid_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start)) else $error("result with no item");
  // The end of a busy stretch delivers a result.
  a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid) else $error("busy ended without a result");
  // A range error carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_result_bits == 64'd0) else $error("error value");
  // Converted values are never negative.
  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_result_bits[63]) else $error("negative result");
endmodule

bind decimal_scientific_to_double_unit dsd_checker u_dsd_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_result_bits(out_result_bits), .out_range_error(out_range_error)
);
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for decimal_scientific_to_double_unit.
// Drives decimal mantissa/exponent items and checks each binary64 result.
// Depends on dsd_pkg and the converter RTL.
`timescale 1ns / 100ps
module tb;
  import dsd_pkg::*;

  typedef struct packed {
    logic [63:0] mantissa;
    logic        exp_neg;
    logic [5:0]  dec_exp;
  } conv_item_t;

  typedef struct packed {
    logic [63:0] bits;
    logic        range_err;
  } conv_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [63:0] in_mantissa;
  logic        in_exponent_negative;
  logic [5:0]  in_decimal_exponent;
  logic        out_valid;
  logic [63:0] out_result_bits;
  logic        out_range_error;

  conv_item_t   pending_items[$];
  conv_result_t expected_doubles[$];
  int           fail_count;
  int           result_count;
  int           range_err_count;
  int           zero_count;
  bit           stim_done;
  bit           hold_sender;
  bit           calm_stretch;

  decimal_scientific_to_double_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mantissa(in_mantissa), .in_exponent_negative(in_exponent_negative),
    .in_decimal_exponent(in_decimal_exponent), .out_valid(out_valid),
    .out_result_bits(out_result_bits), .out_range_error(out_range_error)
  );

  // Clock with a 10 ns period.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Index of the highest set bit of a nonzero 128-bit value.
  function automatic int msb128(input logic [127:0] x);
    int p;
    p = 0;
    for (int i = 0; i < 128; i++) if (x[i]) p = i;
    return p;
  endfunction

  // Predicts the binary64 pattern for one item.
  function automatic conv_result_t predict_double(input conv_item_t it);
    conv_result_t r;
    logic [127:0] wide;
    logic [127:0] p5;
    logic [63:0]  top;
    logic [63:0]  frac;
    logic [63:0]  half;
    logic [63:0]  sig;
    int           bexp;
    int           lg;
    int           sh;
    int           p;
    int           d;
    int           nsh;
    int           biased;
    r = '0;
    if (it.dec_exp > MaxExponent) begin
      r.range_err = 1'b1;
      return r;
    end
    if (it.mantissa == 64'd0) return r;
    p5 = 128'd1;
    for (int i = 0; i < it.dec_exp; i++) p5 = p5 * 128'd5;
    if (!it.exp_neg) begin
      wide = {64'd0, it.mantissa} * p5;
      bexp = it.dec_exp;
    end else begin
      nsh = 64 - msb128({64'd0, it.mantissa});
      wide = {64'd0, it.mantissa} << (3 * it.dec_exp + nsh);
      wide = wide / p5;
      bexp = -4 * int'(it.dec_exp) - nsh;
    end
    lg = msb128(wide);
    sh = (lg > 63) ? lg - 63 : 0;
    top = 64'(wide >> sh);
    if (top == 64'd0) return r;
    p = msb128({64'd0, top});
    if (p <= 52) begin
      sig = top << (52 - p);
    end else begin
      d = p - 52;
      frac = top & ((64'd1 << d) - 64'd1);
      half = 64'd1 << (d - 1);
      sig = top >> d;
      if (frac > half || (frac == half && sig[0])) sig = sig + 64'd1;
      if (sig == (64'd1 << 53)) begin
        sig = sig >> 1;
        p++;
      end
    end
    biased = p + int'(ExpBias) + bexp + sh;
    r.bits = {1'b0, biased[10:0], sig[51:0]};
    return r;
  endfunction

  // Queues an item; the sender queues its expected result when the item is taken.
  task automatic add_item(input logic [63:0] m, input logic neg, input logic [5:0] e);
    conv_item_t it;
    it.mantissa = m;
    it.exp_neg = neg;
    it.dec_exp = e;
    pending_items.push_back(it);
  endtask

  // Sender: one item at a time, with random idle cycles outside calm stretches.
  always @(posedge clk) begin
    conv_item_t it;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_doubles.push_back(predict_double({in_mantissa, in_exponent_negative,
                                                 in_decimal_exponent}));
      start <= 1'b0;
    end else if (!start && !hold_sender && pending_items.size() > 0 &&
                 (calm_stretch || $urandom_range(99) >= 12)) begin
      it = pending_items.pop_front();
      in_mantissa <= it.mantissa;
      in_exponent_negative <= it.exp_neg;
      in_decimal_exponent <= it.dec_exp;
      start <= 1'b1;
    end
  end

  // Result checker: compares each strobe with the oldest expectation.
  always @(posedge clk) begin
    conv_result_t want;
    if (rst_n && out_valid) begin
      if (expected_doubles.size() == 0) begin
        $error("unexpected result bits=%h range_error=%b", out_result_bits, out_range_error);
        fail_count++;
      end else begin
        want = expected_doubles.pop_front();
        result_count++;
        if (want.range_err) range_err_count++;
        if (!want.range_err && want.bits == 64'd0) zero_count++;
        if (out_result_bits !== want.bits) begin
          $error("result_bits expected %h actual %h", want.bits, out_result_bits);
          fail_count++;
        end
        if (out_range_error !== want.range_err) begin
          $error("range_error expected %b actual %b", want.range_err, out_range_error);
          fail_count++;
        end
      end
    end
  end

  // Random mantissa with a random bit length so small and large values both appear.
  function automatic logic [63:0] rand_mantissa();
    logic [63:0] m;
    int          w;
    m = {$urandom, $urandom};
    w = $urandom_range(64, 1);
    if (w < 64) m = m & ((64'd1 << w) - 64'd1);
    if ($urandom_range(19) == 0) m = 64'd0;
    return m;
  endfunction

  // Stimulus: directed extremes, then random items with a full drain midway.
  initial begin
    logic [5:0] e;
    fail_count = 0;
    result_count = 0;
    range_err_count = 0;
    zero_count = 0;
    stim_done = 1'b0;
    hold_sender = 1'b0;
    calm_stretch = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_mantissa = '0;
    in_exponent_negative = 1'b0;
    in_decimal_exponent = '0;

    // Extremes, both exponent signs, zero mantissa and out-of-range exponents.
    add_item(64'd0, 1'b0, 6'd0);
    add_item(64'd0, 1'b1, 6'd20);
    add_item(64'd1, 1'b0, 6'd0);
    add_item(64'd1, 1'b1, 6'd0);
    add_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 6'd20);
    add_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 6'd20);
    add_item(64'd1, 1'b1, 6'd20);
    add_item(64'd1, 1'b0, 6'd20);
    add_item(64'd123456789, 1'b0, 6'd21);
    add_item(64'd5, 1'b1, 6'd63);
    add_item(64'd0, 1'b0, 6'd63);
    add_item(64'h8000_0000_0000_0000, 1'b1, 6'd1);
    add_item(64'h0020_0000_0000_0001, 1'b0, 6'd0);
    add_item(64'h0020_0000_0000_0003, 1'b0, 6'd0);
    add_item(64'h001F_FFFF_FFFF_FFFF, 1'b1, 6'd10);
    add_item(64'd25, 1'b1, 6'd2);
    add_item(64'd7, 1'b0, 6'd15);
    add_item(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 6'd42);
    add_item(64'h5555_5555_5555_5555, 1'b1, 6'd21);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Random items; exponents mostly in range, some errors.
    for (int n = 0; n < 1050; n++) begin
      if ($urandom_range(9) == 0) e = 6'($urandom_range(63, 21));
      else e = 6'($urandom_range(20));
      add_item(rand_mantissa(), 1'($urandom_range(1)), e);
      // Drain everything once midway, then run a stretch without idles.
      if (n == 500) begin
        wait (pending_items.size() == 0);
        @(posedge clk);
        hold_sender = 1'b1;
        wait (!start && expected_doubles.size() == 0);
        repeat (3) @(posedge clk);
        hold_sender = 1'b0;
        calm_stretch = 1'b1;
      end
      // The calm stretch covers every item queued since the drain.
      if (n == 700) begin
        wait (pending_items.size() == 0);
        calm_stretch = 1'b0;
      end
    end
    wait (pending_items.size() == 0 && !start);
    wait (expected_doubles.size() == 0);
    repeat (400) @(posedge clk);
    stim_done = 1'b1;
  end

  // Final report.
  initial begin
    wait (stim_done);
    if (expected_doubles.size() != 0) fail_count++;
    $display("Checked %0d conversions of both exponent signs, %0d range errors, %0d zeros.",
             result_count, range_err_count, zero_count);
    if (fail_count == 0) begin
      $display("decimal_scientific_to_double_unit verification clean");
    end else begin
      $display("decimal_scientific_to_double_unit verification failed");
    end
    $finish;
  end

  // Timeout: about 1100 items, with their expected run time taken several times over.
  initial begin
    #20_000_000;
    $display("decimal_scientific_to_double_unit verification failed");
    $finish;
  end
endmodule

>>> files.f
rtl/dsd_pkg.sv
rtl/decimal_scientific_to_double_unit.sv
rtl/dsd_checker.sv
tb/tb.sv
